FILE: sv/pfs_pkg.sv
// Shared types and constants for the pixel frame statistics unit.
// No dependencies; imported by every module of the unit.
package pfs_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int CFG_W          = 13;
    localparam int POS_W          = 12;
    localparam int CH_W           = 8;
    localparam int SUM_W          = 10;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET   = CFG_W'(640);
    localparam logic [SUM_W-1:0] DARK_SUM_INIT = SUM_W'(256 * 3);
    localparam logic [CH_W-1:0]  CH_MAX_VAL    = CH_W'(255);

    typedef enum logic [1:0] {
        RK_BRIGHTEST = 2'd0,
        RK_DARKEST   = 2'd1,
        RK_CH_MAX    = 2'd2,
        RK_CH_MIN    = 2'd3
    } t_report_kind;

    typedef enum logic {
        BK_RUN,
        BK_REPORT
    } t_back_state;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            end_of_frame;
    } t_pix;

    typedef struct packed {
        t_report_kind     report_kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [CH_W-1:0]  val_r;
        logic [CH_W-1:0]  val_g;
        logic [CH_W-1:0]  val_b;
        logic             last_of_run;
    } t_report;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
    } t_pix_rec;

    typedef struct packed {
        t_pix_rec         pix;
        logic [SUM_W-1:0] sum;
        logic             eof;
    } t_work;

endpackage

FILE: sv/pfs_front.sv
// Front end: accepts pixels, tracks column and row, computes the R+G+B sum.
// Depends on pfs_pkg; feeds pfs_queue.
module pfs_front #(
    parameter int MAX_WIDTH  = pfs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pfs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pfs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_pix_valid,
    output logic                      o_pix_ready,
    input  pfs_pkg::t_pix             i_pix,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output pfs_pkg::t_work            o_q_data
);
    import pfs_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0] W_MAX    = WW'(MAX_WIDTH);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

    logic [CFG_W-1:0] r_image_width;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [WW-1:0]    w_ext, w_eff, col_inc;
    logic             accept;

    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && o_pix_ready;
    assign o_q_push    = accept;

    always_comb begin
        o_q_data.pix.x = POS_W'(r_col);
        o_q_data.pix.y = POS_W'(r_row);
        o_q_data.pix.r = i_pix.red;
        o_q_data.pix.g = i_pix.green;
        o_q_data.pix.b = i_pix.blue;
        o_q_data.sum   = SUM_W'(i_pix.red) + SUM_W'(i_pix.green) + SUM_W'(i_pix.blue);
        o_q_data.eof   = i_pix.end_of_frame;
    end

    always_comb begin
        w_ext = WW'(r_image_width);
        priority if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_ext;
        end
        col_inc = WW'(r_col) + WW'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            priority if (i_pix.end_of_frame) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= w_eff) begin
                n_col = '0;
                if (r_row != ROW_LAST) begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_RESET;
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_image_width <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: sv/pfs_queue.sv
// Short FIFO of classified pixels between the front end and the statistics back end.
// Depends on pfs_pkg for the entry type and depth.
module pfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pfs_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pfs_pkg::t_work o_head
);
    import pfs_pkg::*;

    localparam int QA = $clog2(QUEUE_DEPTH);

    t_work         r_mem [QUEUE_DEPTH];
    logic [QA-1:0] r_wr_ptr, r_rd_ptr;
    logic [QA:0]   r_count;

    assign o_full  = (r_count == (QA+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QA'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QA'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QA+1)'(1);
                2'b01:   r_count <= r_count - (QA+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/pfs_back.sv
// Back end: folds queued pixels into the frame statistics and issues four reports per frame.
// Depends on pfs_pkg; drains pfs_queue and drives the registered report output.
module pfs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  pfs_pkg::t_work   i_q_head,
    output logic             o_q_pop,
    output logic             o_rpt_valid,
    input  logic             i_rpt_ready,
    output pfs_pkg::t_report o_rpt
);
    import pfs_pkg::*;

    t_back_state      r_state, n_state;
    t_report_kind     r_kind, n_kind;
    logic             r_out_valid, n_out_valid;
    t_report          r_out, n_out;
    logic             r_bright_valid, n_bright_valid;
    logic [SUM_W-1:0] r_bright_sum, n_bright_sum;
    t_pix_rec         r_bright, n_bright;
    logic [SUM_W-1:0] r_dark_sum, n_dark_sum;
    t_pix_rec         r_dark, n_dark;
    logic [CH_W-1:0]  r_max [3];
    logic [CH_W-1:0]  n_max [3];
    logic [CH_W-1:0]  r_min [3];
    logic [CH_W-1:0]  n_min [3];
    logic [CH_W-1:0]  px [3];
    logic             out_free;

    assign o_rpt_valid = r_out_valid;
    assign o_rpt       = r_out;
    assign out_free    = !r_out_valid || i_rpt_ready;

    always_comb begin
        px[0] = i_q_head.pix.r;
        px[1] = i_q_head.pix.g;
        px[2] = i_q_head.pix.b;

        n_state        = r_state;
        n_kind         = r_kind;
        n_out_valid    = r_out_valid && !i_rpt_ready;
        n_out          = r_out;
        n_bright_valid = r_bright_valid;
        n_bright_sum   = r_bright_sum;
        n_bright       = r_bright;
        n_dark_sum     = r_dark_sum;
        n_dark         = r_dark;
        n_max          = r_max;
        n_min          = r_min;
        o_q_pop        = 1'b0;

        unique case (r_state)
            BK_RUN: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (!r_bright_valid || i_q_head.sum > r_bright_sum) begin
                        n_bright_valid = 1'b1;
                        n_bright_sum   = i_q_head.sum;
                        n_bright       = i_q_head.pix;
                    end
                    if (i_q_head.sum < r_dark_sum) begin
                        n_dark_sum = i_q_head.sum;
                        n_dark     = i_q_head.pix;
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (px[i] > r_max[i]) begin
                            n_max[i] = px[i];
                        end
                        if (px[i] < r_min[i]) begin
                            n_min[i] = px[i];
                        end
                    end
                    if (i_q_head.eof) begin
                        n_state = BK_REPORT;
                        n_kind  = RK_BRIGHTEST;
                    end
                end
            end
            BK_REPORT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.report_kind = r_kind;
                    n_out.last_of_run = 1'b0;
                    unique case (r_kind)
                        RK_BRIGHTEST: begin
                            n_out.pos_x = r_bright.x;
                            n_out.pos_y = r_bright.y;
                            n_out.val_r = r_bright.r;
                            n_out.val_g = r_bright.g;
                            n_out.val_b = r_bright.b;
                            n_kind      = RK_DARKEST;
                        end
                        RK_DARKEST: begin
                            n_out.pos_x = r_dark.x;
                            n_out.pos_y = r_dark.y;
                            n_out.val_r = r_dark.r;
                            n_out.val_g = r_dark.g;
                            n_out.val_b = r_dark.b;
                            n_kind      = RK_CH_MAX;
                        end
                        RK_CH_MAX: begin
                            n_out.pos_x = '0;
                            n_out.pos_y = '0;
                            n_out.val_r = r_max[0];
                            n_out.val_g = r_max[1];
                            n_out.val_b = r_max[2];
                            n_kind      = RK_CH_MIN;
                        end
                        RK_CH_MIN: begin
                            n_out.pos_x       = '0;
                            n_out.pos_y       = '0;
                            n_out.val_r       = r_min[0];
                            n_out.val_g       = r_min[1];
                            n_out.val_b       = r_min[2];
                            n_out.last_of_run = 1'b1;
                            n_kind            = RK_BRIGHTEST;
                            n_state           = BK_RUN;
                            n_bright_valid    = 1'b0;
                            n_bright_sum      = '0;
                            n_bright          = '0;
                            n_dark_sum        = DARK_SUM_INIT;
                            n_dark            = '0;
                            for (int i = 0; i < 3; i++) begin
                                n_max[i] = '0;
                                n_min[i] = CH_MAX_VAL;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BK_RUN;
            r_kind         <= RK_BRIGHTEST;
            r_out_valid    <= 1'b0;
            r_bright_valid <= 1'b0;
            r_bright_sum   <= '0;
            r_bright       <= '0;
            r_dark_sum     <= DARK_SUM_INIT;
            r_dark         <= '0;
            for (int i = 0; i < 3; i++) begin
                r_max[i] <= '0;
                r_min[i] <= CH_MAX_VAL;
            end
        end else begin
            r_state        <= n_state;
            r_kind         <= n_kind;
            r_out_valid    <= n_out_valid;
            r_bright_valid <= n_bright_valid;
            r_bright_sum   <= n_bright_sum;
            r_bright       <= n_bright;
            r_dark_sum     <= n_dark_sum;
            r_dark         <= n_dark;
            r_max          <= n_max;
            r_min          <= n_min;
        end
    end

endmodule

FILE: sv/pixel_frame_statistics_unit.sv
// Pixel frame statistics unit: top level joining front end, queue and back end.
// Depends on pfs_pkg, pfs_front, pfs_queue and pfs_back.
//
// Pixels arrive in raster order on the input channel, one beat per pixel, with
// end_of_frame set on the last pixel of a frame. The user is to write the image
// width register through i_cfg_we / i_cfg_wdata only between frames; the unit
// itself does not enforce this. The unit accepts one pixel per clock while the
// queue is not full; a pixel enters a four-entry queue in the cycle after it is
// accepted, and the back end folds it into the statistics when it pops it.
// At the end-of-frame pixel the back end issues four report beats (brightest,
// darkest, channel maxima, channel minima), one per cycle while the receiver
// takes them, each held in the registered report output. The back end takes no
// queued pixel during the burst; the queue hides the burst only when the input
// idles between frames, otherwise input ready drops while the queue is full.
// When the receiver stalls, the registered report holds and the queue fills;
// input ready drops only once the queue is full.
// Reset clears the counters, the statistics and the queue, and sets the width
// to 640.
module pixel_frame_statistics_unit #(
    parameter int MAX_WIDTH  = pfs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pfs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pfs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_pix_valid,
    output logic                      o_pix_ready,
    input  pfs_pkg::t_pix             i_pix,
    output logic                      o_rpt_valid,
    input  logic                      i_rpt_ready,
    output pfs_pkg::t_report          o_rpt
);
    import pfs_pkg::*;

    logic  q_full, q_push, q_pop, q_empty;
    t_work q_in, q_head;

    pfs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    pfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_rpt_valid (o_rpt_valid),
        .i_rpt_ready (i_rpt_ready),
        .o_rpt       (o_rpt)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for pixel_frame_statistics_unit: pixel streams in, frame reports out.
// It predicts every report from its own model and compares field by field.
// It depends on pfs_pkg and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 120;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 7;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_pix_valid = 1'b0;
    logic             o_pix_ready;
    t_pix             i_pix       = '0;
    logic             o_rpt_valid;
    logic             i_rpt_ready = 1'b0;
    t_report          o_rpt;

    pixel_frame_statistics_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_rpt_valid (o_rpt_valid),
        .i_rpt_ready (i_rpt_ready),
        .o_rpt       (o_rpt)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Frame statistics as the unit should hold them.
    logic [CFG_W-1:0] width_reg = WIDTH_RESET;
    int unsigned      column;
    int unsigned      row;
    bit               bright_seen;
    int unsigned      bright_sum;
    int unsigned      dark_sum;
    t_pix_rec         bright_rec;
    t_pix_rec         dark_rec;
    logic [CH_W-1:0]  ch_max [3];
    logic [CH_W-1:0]  ch_min [3];

    t_pix    pix_q [$];
    t_report pending_reports [$];
    t_report want_rpt;

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    int  src_gap       = 0;
    int  sink_gap      = 0;
    int  hold_req      = 0;
    int  hold_seen     = 0;
    int  hold_left     = 0;
    bit  pix_taken     = 1'b0;
    int  mismatches    = 0;
    int  pixels_taken  = 0;
    int  frames_seen   = 0;
    int  reports_seen  = 0;
    int  width_writes  = 0;
    int  cycle_count   = 0;

    function automatic void clear_stats();
        column      = 0;
        row         = 0;
        bright_seen = 1'b0;
        bright_sum  = 0;
        bright_rec  = '0;
        dark_sum    = DARK_SUM_INIT;
        dark_rec    = '0;
        for (int i = 0; i < 3; i++) begin
            ch_max[i] = '0;
            ch_min[i] = CH_MAX_VAL;
        end
    endfunction

    function automatic t_report make_report(t_report_kind kind, t_pix_rec rec, bit last);
        t_report rpt;
        rpt.report_kind = kind;
        rpt.pos_x       = rec.x;
        rpt.pos_y       = rec.y;
        rpt.val_r       = rec.r;
        rpt.val_g       = rec.g;
        rpt.val_b       = rec.b;
        rpt.last_of_run = last;
        return rpt;
    endfunction

    function automatic void fold_pixel(t_pix p);
        logic [CH_W-1:0] ch [3];
        int unsigned     sum;
        int unsigned     w;
        t_pix_rec        here;
        t_pix_rec        hi;
        t_pix_rec        lo;
        ch[0]  = p.red;
        ch[1]  = p.green;
        ch[2]  = p.blue;
        sum    = ch[0] + ch[1] + ch[2];
        here.x = POS_W'(column);
        here.y = POS_W'(row);
        here.r = ch[0];
        here.g = ch[1];
        here.b = ch[2];
        if (!bright_seen || sum > bright_sum) begin
            bright_seen = 1'b1;
            bright_sum  = sum;
            bright_rec  = here;
        end
        if (sum < dark_sum) begin
            dark_sum = sum;
            dark_rec = here;
        end
        for (int i = 0; i < 3; i++) begin
            if (ch[i] > ch_max[i]) ch_max[i] = ch[i];
            if (ch[i] < ch_min[i]) ch_min[i] = ch[i];
        end
        if (p.end_of_frame) begin
            hi   = '0;
            hi.r = ch_max[0];
            hi.g = ch_max[1];
            hi.b = ch_max[2];
            lo   = '0;
            lo.r = ch_min[0];
            lo.g = ch_min[1];
            lo.b = ch_min[2];
            pending_reports.push_back(make_report(RK_BRIGHTEST, bright_rec, 1'b0));
            pending_reports.push_back(make_report(RK_DARKEST, dark_rec, 1'b0));
            pending_reports.push_back(make_report(RK_CH_MAX, hi, 1'b0));
            pending_reports.push_back(make_report(RK_CH_MIN, lo, 1'b1));
            frames_seen++;
            clear_stats();
        end else begin
            w = width_reg;
            if (w < 1) w = 1;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            if (column + 1 >= w) begin
                column = 0;
                if (row + 1 < DEF_MAX_HEIGHT) row = row + 1;
            end else begin
                column = column + 1;
            end
        end
    endfunction

    function automatic void queue_pixel(int r, int g, int b, bit eof);
        t_pix p;
        p.red          = CH_W'(r);
        p.green        = CH_W'(g);
        p.blue         = CH_W'(b);
        p.end_of_frame = eof;
        pix_q.push_back(p);
    endfunction

    function automatic int pick_level();
        case ($urandom_range(3))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic wait_quiet();
        while (pix_q.size() != 0 || i_pix_valid || pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_width(int unsigned v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        width_reg    = CFG_W'(v);
        width_writes++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_pix_valid && o_pix_ready) begin
            fold_pixel(i_pix);
            pixels_taken++;
        end
        pix_taken <= i_rst_n && i_pix_valid && o_pix_ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else if (i_pix_valid && !pix_taken) begin
        end else if (src_gap > 0) begin
            src_gap--;
            i_pix_valid <= 1'b0;
        end else if (pix_q.size() != 0 && $urandom_range(99) < src_idle_pct) begin
            src_gap = $urandom_range(18, 0);
            i_pix_valid <= 1'b0;
        end else if (pix_q.size() != 0) begin
            i_pix       <= pix_q.pop_front();
            i_pix_valid <= 1'b1;
        end else begin
            i_pix_valid <= 1'b0;
        end
    end

    // The long hold is counted here so that the sender keeps offering beats meanwhile.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rpt_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            i_rpt_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_rpt_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_rpt_ready <= 1'b0;
        end else if ($urandom_range(99) < sink_idle_pct) begin
            sink_gap = $urandom_range(18, 0);
            i_rpt_ready <= 1'b0;
        end else begin
            i_rpt_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rpt_valid && i_rpt_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: kind %0d x %0d y %0d rgb %0d/%0d/%0d last %0d",
                             o_rpt.report_kind, o_rpt.pos_x, o_rpt.pos_y, o_rpt.val_r,
                             o_rpt.val_g, o_rpt.val_b, o_rpt.last_of_run);
            end else begin
                want_rpt = pending_reports.pop_front();
                reports_seen++;
                if (o_rpt.report_kind !== want_rpt.report_kind ||
                    o_rpt.pos_x !== want_rpt.pos_x || o_rpt.pos_y !== want_rpt.pos_y ||
                    o_rpt.val_r !== want_rpt.val_r || o_rpt.val_g !== want_rpt.val_g ||
                    o_rpt.val_b !== want_rpt.val_b ||
                    o_rpt.last_of_run !== want_rpt.last_of_run) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report %0d: expected kind %0d x %0d y %0d rgb %0d/%0d/%0d last %0d",
                                 reports_seen, want_rpt.report_kind, want_rpt.pos_x,
                                 want_rpt.pos_y, want_rpt.val_r, want_rpt.val_g,
                                 want_rpt.val_b, want_rpt.last_of_run);
                        $display("report %0d: actual   kind %0d x %0d y %0d rgb %0d/%0d/%0d last %0d",
                                 reports_seen, o_rpt.report_kind, o_rpt.pos_x, o_rpt.pos_y,
                                 o_rpt.val_r, o_rpt.val_g, o_rpt.val_b, o_rpt.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int n;
        clear_stats();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames, starting at the reset width.
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        queue_pixel(255, 255, 255, 1'b1);
        queue_pixel(0, 0, 0, 1'b1);
        wait_quiet();

        // Equal sums must keep the first pixel for both extremes.
        set_width(3);
        queue_pixel(10, 20, 30, 1'b0);
        queue_pixel(30, 20, 10, 1'b0);
        queue_pixel(0, 0, 0, 1'b0);
        queue_pixel(0, 0, 0, 1'b0);
        queue_pixel(255, 255, 255, 1'b0);
        queue_pixel(255, 255, 255, 1'b0);
        queue_pixel(1, 2, 3, 1'b1);
        wait_quiet();

        set_width(0);
        queue_pixel(5, 5, 5, 1'b0);
        queue_pixel(0, 0, 1, 1'b0);
        queue_pixel(9, 9, 9, 1'b0);
        queue_pixel(200, 0, 0, 1'b1);
        wait_quiet();

        set_width(8191);
        queue_pixel(1, 1, 1, 1'b0);
        queue_pixel(2, 2, 2, 1'b0);
        queue_pixel(0, 255, 0, 1'b1);
        wait_quiet();

        // Narrow the width in the middle of a frame.
        set_width(4);
        queue_pixel(7, 7, 7, 1'b0);
        queue_pixel(8, 8, 8, 1'b0);
        queue_pixel(6, 6, 6, 1'b0);
        wait_quiet();
        set_width(2);
        queue_pixel(100, 100, 100, 1'b0);
        queue_pixel(1, 1, 1, 1'b0);
        queue_pixel(50, 60, 70, 1'b1);
        wait_quiet();

        // Random frames; they often span a width change.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(9))
                0: set_width(0);
                1: set_width(8191);
                2: set_width(DEF_MAX_WIDTH);
                3: set_width($urandom_range(8191, 4097));
                4: set_width(1);
                default: set_width($urandom_range(12, 2));
            endcase
            case ($urandom_range(2))
                0: src_idle_pct = 0;
                1: src_idle_pct = 15;
                default: src_idle_pct = 40;
            endcase
            case ($urandom_range(2))
                0: sink_idle_pct = 0;
                1: sink_idle_pct = 15;
                default: sink_idle_pct = 40;
            endcase
            for (int k = 0; k < 15; k++)
                queue_pixel(pick_level(), pick_level(), pick_level(), $urandom_range(5) == 0);
            wait_quiet();
        end

        // The receiver stalls for a long stretch while short frames keep coming.
        set_width(2);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req++;
        for (int f = 0; f < 8; f++) begin
            for (int k = 0; k < 3; k++)
                queue_pixel(pick_level(), pick_level(), pick_level(), k == 2);
        end
        wait_quiet();

        // Closing stretch at full rate on both sides.
        set_width($urandom_range(6, 2));
        n = 30;
        for (int k = 0; k < n; k++)
            queue_pixel(pick_level(), pick_level(), pick_level(),
                        (k == n - 1) || ($urandom_range(7) == 0));
        wait_quiet();

        mismatches += pending_reports.size();
        $display("covered %0d pixels in %0d frames over %0d width settings",
                 pixels_taken, frames_seen, width_writes);
        $display("checked %0d reports, %0d failures", reports_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
